FILE: rtl/hevc_access_unit_boundary_finder_defines.svh
// Assertion macros for the access unit boundary finder checker.
// Depends on nothing; included by the checker file.
`ifndef HEVC_ACCESS_UNIT_BOUNDARY_FINDER_DEFINES_SVH
`define HEVC_ACCESS_UNIT_BOUNDARY_FINDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AUB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AUB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/hevcaub_pkg.sv
// Shared constants, types and helpers for the access unit boundary finder.
// Depends on nothing; used by hevcaub_scan and the top level.
package hevcaub_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int FIELD_BITS  = 24;
   localparam int WIN_BYTES   = 4;
   localparam int RSP_BITS    = 56;
   localparam int PAD_BITS    = RSP_BITS - 2 - 2 * FIELD_BITS;

   localparam logic [2:0] SKIP_RESET = 3'd5;
   localparam logic [2:0] SKIP_CODE  = 3'd4;

   localparam logic [5:0] NAL_VPS     = 6'h20;
   localparam logic [5:0] NAL_SPS     = 6'h21;
   localparam logic [5:0] NAL_PPS     = 6'h22;
   localparam logic [5:0] NAL_SEI     = 6'h27;
   localparam logic [5:0] NAL_VCL_MAX = 6'h15;

   localparam logic [1:0] STATUS_FRAME = 2'd0;
   localparam logic [1:0] STATUS_OPEN  = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   typedef struct packed {
      logic step;
      logic clear;
      logic armed;
   } scan_ctl_type;

   typedef struct packed {
      logic hit;
      logic four;
   } code_type;

   function automatic logic [5:0] nal_type(input logic [7:0] header);
      nal_type = header[6:1];
   endfunction

endpackage

FILE: rtl/hevcaub_scan.sv
// Start code scanner: byte history and skip counter, flags a matched code.
// Depends on hevcaub_pkg.
module hevcaub_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               stream_byte,
   input  hevcaub_pkg::scan_ctl_type ctl,
   output hevcaub_pkg::code_type    code
);

   logic [7:0] window_ff [hevcaub_pkg::WIN_BYTES];
   logic [7:0] window_in [hevcaub_pkg::WIN_BYTES];
   logic [2:0] skip_ff;
   logic [2:0] skip_in;
   logic [2:0] skip_dec;
   logic       four;
   logic       three;

   always_comb begin
      skip_dec = (skip_ff != 3'd0) ? skip_ff - 3'd1 : 3'd0;
      four  = (skip_dec == 3'd0) && (window_ff[0] == 8'h00) && (window_ff[1] == 8'h00)
              && (window_ff[2] == 8'h00) && (window_ff[3] == 8'h01);
      three = (skip_dec <= 3'd1) && (window_ff[1] == 8'h00) && (window_ff[2] == 8'h00)
              && (window_ff[3] == 8'h01);
      code.hit  = ctl.armed && (four || three);
      code.four = four;
   end

   always_comb begin
      window_in = window_ff;
      skip_in   = skip_ff;
      if (ctl.step) begin
         if (ctl.clear) begin
            for (int k = 0; k < hevcaub_pkg::WIN_BYTES; k++) begin
               window_in[k] = 8'h00;
            end
            skip_in = hevcaub_pkg::SKIP_RESET;
         end else begin
            for (int k = 0; k < hevcaub_pkg::WIN_BYTES - 1; k++) begin
               window_in[k] = window_ff[k + 1];
            end
            window_in[hevcaub_pkg::WIN_BYTES - 1] = stream_byte;
            skip_in = code.hit ? hevcaub_pkg::SKIP_CODE : skip_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < hevcaub_pkg::WIN_BYTES; k++) begin
            window_ff[k] <= 8'h00;
         end
         skip_ff <= hevcaub_pkg::SKIP_RESET;
      end else begin
         window_ff <= window_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

FILE: rtl/hevc_access_unit_boundary_finder.sv
// A result word appears on rsp in the cycle after the req word that causes it is accepted.
// Throughput: one byte per cycle; req_tready drops only while a result waits unread.
// The single result register lets the next byte in as the pending result is taken.
// Reset (synchronous, active high) clears the scan state and mode; the last byte
// of each buffer also returns the scan state, but not the mode, to reset values.
// Depends on hevcaub_pkg and hevcaub_scan.
module hevc_access_unit_boundary_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,   // header_only_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [1:0] status, [25:2] frame_start_offset,
                                    // [49:26] frame_length, [55:50] zero
);

   localparam int OB = hevcaub_pkg::OFFSET_BITS;
   localparam int FB = hevcaub_pkg::FIELD_BITS;

   logic                 mode_ff;
   logic [OB-1:0]        pos_ff, pos_in;
   logic [1:0]           pics_ff, pics_in;
   logic [1:0]           hdrs_ff, hdrs_in;
   logic [OB-1:0]        frame_begin_ff, frame_begin_in;
   logic                 sent_ff, sent_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [hevcaub_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   hevcaub_pkg::scan_ctl_type scan_ctl;
   hevcaub_pkg::code_type     code;

   logic          accept;
   logic [5:0]    typ;
   logic          is_hdr;
   logic          is_vcl;
   logic [OB-1:0] code_start;
   logic [1:0]    pics_n;
   logic [1:0]    hdrs_n;
   logic [OB-1:0] begin_n;
   logic          done;
   logic          emit;
   logic [OB-1:0] frame_len;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign scan_ctl.step  = accept;
   assign scan_ctl.clear = req_tlast;
   assign scan_ctl.armed = !sent_ff;

   hevcaub_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .stream_byte (req_tdata),
      .ctl         (scan_ctl),
      .code        (code)
   );

   always_comb begin
      typ    = hevcaub_pkg::nal_type(req_tdata);
      is_hdr = (typ == hevcaub_pkg::NAL_VPS) || (typ == hevcaub_pkg::NAL_SPS)
               || (typ == hevcaub_pkg::NAL_PPS) || (typ == hevcaub_pkg::NAL_SEI);
      is_vcl = (typ <= hevcaub_pkg::NAL_VCL_MAX);
      code_start = pos_ff - (code.four ? OB'(4) : OB'(3));

      pics_n  = pics_ff;
      hdrs_n  = hdrs_ff;
      begin_n = frame_begin_ff;
      done    = 1'b0;
      if (code.hit) begin
         if (is_hdr) begin
            if (hdrs_ff != 2'd2) begin
               hdrs_n = hdrs_ff + 2'd1;
            end
            if ((pics_ff == 2'd0) && (hdrs_n == 2'd1)) begin
               begin_n = code_start;
            end
            if (pics_ff == 2'd1) begin
               pics_n = 2'd2;
            end
         end
         if (is_vcl) begin
            if (mode_ff) begin
               done = 1'b1;
            end else begin
               pics_n = pics_n + 2'd1;
               if ((pics_n == 2'd1) && (hdrs_n == 2'd0)) begin
                  begin_n = code_start;
               end
            end
         end
         if (pics_n[1]) begin
            done = 1'b1;
         end
      end
      frame_len = code_start - begin_n;
      emit      = accept && (done || (req_tlast && !sent_ff));

      if (done) begin
         rsp_data_in = {{hevcaub_pkg::PAD_BITS{1'b0}}, FB'(frame_len), FB'(begin_n),
                        hevcaub_pkg::STATUS_FRAME};
      end else begin
         rsp_data_in = {{hevcaub_pkg::PAD_BITS{1'b0}}, {(2 * FB){1'b0}},
                        (pics_n == 2'd1) ? hevcaub_pkg::STATUS_OPEN
                                         : hevcaub_pkg::STATUS_NONE};
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);

      pos_in         = pos_ff;
      pics_in        = pics_ff;
      hdrs_in        = hdrs_ff;
      frame_begin_in = frame_begin_ff;
      sent_in        = sent_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in         = '0;
            pics_in        = 2'd0;
            hdrs_in        = 2'd0;
            frame_begin_in = '0;
            sent_in        = 1'b0;
         end else begin
            pos_in         = pos_ff + OB'(1);
            pics_in        = pics_n;
            hdrs_in        = hdrs_n;
            frame_begin_in = begin_n;
            sent_in        = sent_ff || done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         pos_ff         <= '0;
         pics_ff        <= 2'd0;
         hdrs_ff        <= 2'd0;
         frame_begin_ff <= '0;
         sent_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         pos_ff         <= pos_in;
         pics_ff        <= pics_in;
         hdrs_ff        <= hdrs_in;
         frame_begin_ff <= frame_begin_in;
         sent_ff        <= sent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: rtl/hevcaub_checker.sv
// Port-level checker for the access unit boundary finder, bound to the top level.
// Depends on hevc_access_unit_boundary_finder_defines.svh and hevcaub_pkg.
`include "hevc_access_unit_boundary_finder_defines.svh"

module hevcaub_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   logic [1:0] rsp_status;
   logic       status_ok;
   logic       frame_word;

   assign rsp_status = rsp_tdata[1:0];
   assign status_ok  = rsp_status <= hevcaub_pkg::STATUS_NONE;
   assign frame_word = rsp_status == hevcaub_pkg::STATUS_FRAME;

   `AUB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `AUB_ASSERT_NOW(a_status_code, rsp_tvalid, status_ok)
   `AUB_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[55:50] == 6'd0)
   `AUB_ASSERT_NOW(a_no_frame_zero, rsp_tvalid && !frame_word, rsp_tdata[49:2] == 48'd0)
   `AUB_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready)

endmodule

bind hevc_access_unit_boundary_finder hevcaub_checker u_checker (.*);

FILE: tb/sv/tb_hevc_access_unit_boundary_finder.sv
`timescale 1ns / 1ps
// Self-checking testbench for hevc_access_unit_boundary_finder: byte-stream stimulus,
// an in-bench start-code scanner that predicts each unpinned result, and random stalls.
// Depends on hevcaub_pkg and the block's RTL.
module tb_hevc_access_unit_boundary_finder;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 400;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] start_offset;
      logic [23:0] length;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]  value;
      logic        last;
      logic        pinned;
      logic [1:0]  status;
      logic [23:0] start_offset;
      logic [23:0] length;
   } stream_word_type;

   localparam stream_word_type DIRECTED [25] = '{
      '{8'hFF, 1'b1, 1'b1, hevcaub_pkg::STATUS_NONE,  24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h01, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h26, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h01, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h02, 1'b1, 1'b1, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd4},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h01, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h40, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h01, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h26, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h7E, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h81, 1'b1, 1'b1, hevcaub_pkg::STATUS_OPEN,  24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h00, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h01, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'h4E, 1'b0, 1'b0, hevcaub_pkg::STATUS_FRAME, 24'd0, 24'd0},
      '{8'hFF, 1'b1, 1'b1, hevcaub_pkg::STATUS_NONE,  24'd0, 24'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] stream_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // [1:0] status, [25:2] frame_start_offset,
                                    // [49:26] frame_length, [55:50] zero

   hevc_access_unit_boundary_finder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // scanner state
   logic [7:0]    window [5];
   logic [23:0]   pos_count;
   int            skip_left;
   int            pic_count;
   int            hdr_count;
   logic [23:0]   frame_origin;
   bit            frame_done;
   bit            header_only;

   frame_result_type boundary_queue [$];
   stream_word_type  stream_words [$];
   stream_word_type  word_now = '0;
   int               errors = 0;
   int               cycles = 0;
   bit               no_idle = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void clear_scan();
      for (int k = 0; k < 5; k++) window[k] = 8'h00;
      pos_count    = '0;
      skip_left    = int'(hevcaub_pkg::SKIP_RESET);
      pic_count    = 0;
      hdr_count    = 0;
      frame_origin = '0;
      frame_done   = 0;
   endfunction

   function automatic bit find_boundary(input logic [7:0] b, input logic last,
                                        output frame_result_type res);
      logic [23:0] here;
      logic [23:0] code_at;
      logic [5:0]  nal;
      bit          four_code;
      bit          three_code;
      bit          done;
      bit          got;
      here = pos_count;
      for (int k = 0; k < 4; k++) window[k] = window[k + 1];
      window[4] = b;
      if (skip_left > 0) skip_left--;
      pos_count = here + 24'd1;
      got = 0;
      res = '0;
      if (!frame_done) begin
         four_code = skip_left == 0 && window[0] == 8'h00 && window[1] == 8'h00 &&
                     window[2] == 8'h00 && window[3] == 8'h01;
         three_code = skip_left <= 1 && window[1] == 8'h00 && window[2] == 8'h00 &&
                      window[3] == 8'h01;
         if (four_code || three_code) begin
            code_at = here - (four_code ? 24'd4 : 24'd3);
            nal = b[6:1];
            done = 0;
            skip_left = int'(hevcaub_pkg::SKIP_CODE);
            if (nal == hevcaub_pkg::NAL_VPS || nal == hevcaub_pkg::NAL_SPS ||
                nal == hevcaub_pkg::NAL_PPS || nal == hevcaub_pkg::NAL_SEI) begin
               if (hdr_count < 2) hdr_count++;
               if (pic_count == 0 && hdr_count == 1) frame_origin = code_at;
               if (pic_count == 1) pic_count = 2;
            end
            if (nal <= hevcaub_pkg::NAL_VCL_MAX) begin
               if (header_only) begin
                  done = 1;
               end else begin
                  pic_count++;
                  if (pic_count == 1 && hdr_count == 0) frame_origin = code_at;
               end
            end
            if (pic_count >= 2) done = 1;
            if (done) begin
               res.status       = hevcaub_pkg::STATUS_FRAME;
               res.start_offset = frame_origin;
               res.length       = code_at - frame_origin;
               frame_done = 1;
               got = 1;
            end
         end
      end
      if (last) begin
         if (!frame_done) begin
            res.status = (pic_count == 1) ? hevcaub_pkg::STATUS_OPEN
                                          : hevcaub_pkg::STATUS_NONE;
            got = 1;
         end
         clear_scan();
      end
      return got;
   endfunction

   always @(posedge clock) begin
      frame_result_type predicted;
      frame_result_type want;
      bit               produced;
      if (reset) begin
         header_only = 0;
         clear_scan();
      end else begin
         if (csr_wen) header_only = csr_wdata;
         if (req_tvalid && req_tready) begin
            produced = find_boundary(req_tdata, req_tlast, predicted);
            if (word_now.pinned) begin
               predicted.status       = word_now.status;
               predicted.start_offset = word_now.start_offset;
               predicted.length       = word_now.length;
               boundary_queue.push_back(predicted);
            end else if (produced) begin
               boundary_queue.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (boundary_queue.size() == 0) begin
               $display("%0t: no result expected, got status %0d offset %0d length %0d",
                        $time, rsp_tdata[1:0], rsp_tdata[25:2], rsp_tdata[49:26]);
               errors++;
            end else begin
               want = boundary_queue.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_tdata[1:0]);
                  errors++;
               end
               if (rsp_tdata[25:2] !== want.start_offset) begin
                  $display("%0t: start offset expected %0d, got %0d",
                           $time, want.start_offset, rsp_tdata[25:2]);
                  errors++;
               end
               if (rsp_tdata[49:26] !== want.length) begin
                  $display("%0t: length expected %0d, got %0d",
                           $time, want.length, rsp_tdata[49:26]);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold rsp_tready low in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic void add_byte(input logic [7:0] v);
      stream_word_type w;
      w = '0;
      w.value = v;
      stream_words.push_back(w);
   endfunction

   function automatic void add_nal();
      logic [5:0] nal;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         case (pick)
            0: nal = hevcaub_pkg::NAL_VPS;
            1: nal = hevcaub_pkg::NAL_SPS;
            2: nal = hevcaub_pkg::NAL_PPS;
            default: nal = hevcaub_pkg::NAL_SEI;
         endcase
      else if (pick < 8)
         nal = 6'($urandom_range(0, int'(hevcaub_pkg::NAL_VCL_MAX)));
      else
         nal = 6'($urandom_range(int'(hevcaub_pkg::NAL_VCL_MAX) + 1, 63));
      if ($urandom_range(0, 1)) add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h01);
      add_byte({1'($urandom_range(0, 1)), nal, 1'($urandom_range(0, 1))});
      repeat ($urandom_range(0, 6)) begin
         pick = $urandom_range(0, 9);
         add_byte(pick == 0 ? 8'h00 : pick == 1 ? 8'h01 : 8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_buffer();
      stream_word_type w;
      int              kind;
      int              pick;
      kind = $urandom_range(0, 9);
      if (kind < 8) repeat ($urandom_range(1, 5)) add_nal();
      if (kind == 7) begin
         add_byte(8'h00);
         add_byte(8'h00);
         add_byte(8'h01);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(0, 3);
            add_byte(pick < 2 ? 8'h00 : pick == 2 ? 8'h01 : 8'($urandom_range(0, 255)));
         end
      end else if (kind == 9) begin
         add_byte(8'($urandom_range(0, 255)));
      end
      w = stream_words.pop_back();
      w.last = 1'b1;
      stream_words.push_back(w);
   endfunction

   task automatic drive_words();
      foreach (stream_words[i]) begin
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stream_words[i].value;
         req_tlast  <= stream_words[i].last;
         word_now   <= stream_words[i];
         do @(posedge clock); while (!req_tready);
      end
      stream_words.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (boundary_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      int   phase_words;
      logic modes [4];
      modes = '{1'b1, 1'b0, 1'b1, 1'b0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);
      foreach (DIRECTED[i]) stream_words.push_back(DIRECTED[i]);
      drive_words();
      drain();
      foreach (modes[p]) begin
         write_mode(modes[p]);
         if (p == 3) no_idle = 1;
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            build_buffer();
            phase_words += stream_words.size();
            drive_words();
         end
         drain();
      end
      if (errors == 0 && boundary_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
